// ===== sv/cave_cellular_automaton_defines.svh =====
// Assertion helpers for the cave automaton.
// Every check is clocked on clk and is held off while rst_n is low.
`ifndef CAVE_CELLULAR_AUTOMATON_DEFINES_SVH
`define CAVE_CELLULAR_AUTOMATON_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property check
`define CAVE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cave automaton check failed");

// Implication check: cond in this cycle, expect in this cycle
`define CAVE_ASSERT_IMP(label, cond, expect_now) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_now)) \
        else $error("cave automaton check failed");

// Implication check: cond in this cycle, expect in the next cycle
`define CAVE_ASSERT_NEXT(label, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
        else $error("cave automaton check failed");

`else

`define CAVE_ASSERT(label, prop)
`define CAVE_ASSERT_IMP(label, cond, expect_now)
`define CAVE_ASSERT_NEXT(label, cond, expect_next)

`endif

`endif

// ===== sv/cave_ca_pkg.sv =====
`default_nettype none

package cave_ca_pkg;

    // Default grid limits
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Request op codes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] REG_GENERATIONS = 3'd2;
    localparam logic [2:0] REG_FLOOR_TO_WALL = 3'd3;
    localparam logic [2:0] REG_WALL_KEEP   = 3'd4;

    // Configuration reset values
    localparam logic [6:0] RST_GRID_WIDTH    = 7'd64;
    localparam logic [6:0] RST_GRID_HEIGHT   = 7'd64;
    localparam logic [7:0] RST_GENERATIONS   = 8'd5;
    localparam logic [3:0] RST_FLOOR_TO_WALL = 4'd5;
    localparam logic [3:0] RST_WALL_KEEP     = 4'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ACCESS,
        S_LD_WR,
        S_RD_CAP,
        S_GEN_CUR,
        S_GEN_ABOVE,
        S_GEN_BELOW,
        S_GEN_FILL,
        S_GEN_CELL,
        S_GEN_WRITE,
        S_DONE
    } cave_state_t;

endpackage

`default_nettype wire

// ===== sv/cave_ca_ram.sv =====
`default_nettype none

module cave_ca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/cave_cellular_automaton.sv =====
// Cave generator: a 4-5 rule cellular automaton over a grid of wall/floor cells.
// Request channel (req_valid/req_stall) carries op, col, row, cell_in; a
// transaction completes when req_valid is high and req_stall is low. Each
// request gives exactly one response transaction on rsp_valid/rsp_stall with
// cell_out and op_done (op echo).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready. The
// user must write it only while no request is in flight; the block does not enforce this.
// A load or read steps through an access state, a write or capture state and
// the final state, which registers the response and returns to idle once the
// output register is free. Op 3 and a run with zero generations go straight to
// the final state. Each generation of a run sweeps rows 0 to MAX_HEIGHT - 1 of
// one bank of the row memory into the other (one read port, one write port). A
// row in use takes three row reads, a fill step, one step per cell for the shared
// neighbor counter and a row write. Any other row is read and written unchanged.
// One request is in flight at a time; req_stall is high while it is worked on.
// A finished response is held in an output register while rsp_stall is high;
// the sequencer waits in its final step until that register is free.
// Reset returns the registers to 64 x 64, 5 generations, thresholds 5 and 4.
// The grid memory is not cleared: the user must load every cell in use before use; the block does not enforce this.
`default_nettype none
`include "cave_cellular_automaton_defines.svh"

module cave_cellular_automaton
    import cave_ca_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // request channel
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire logic [1:0] op,
    input  wire logic [5:0] col,
    input  wire logic [5:0] row,
    input  wire logic       cell_in,
    // response channel
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output logic            cell_out,
    output logic      [1:0] op_done,
    // configuration channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int EW = ($clog2(MAX_WIDTH + 1) > 7) ? $clog2(MAX_WIDTH + 1) : 7;
    localparam int EH = ($clog2(MAX_HEIGHT + 1) > 7) ? $clog2(MAX_HEIGHT + 1) : 7;
    localparam int AW = YW + 1;
    localparam int RAM_DEPTH = 1 << AW;

    // Configuration registers
    logic [6:0] grid_width_reg;
    logic [6:0] grid_height_reg;
    logic [7:0] generations_reg;
    logic [3:0] f2w_reg;
    logic [3:0] keep_reg;

    // Sequencer and counters
    cave_state_t    state_reg, state_next;
    logic           bank_reg, bank_next;
    logic [EW-1:0]  x_reg, x_next;
    logic [EH-1:0]  y_reg, y_next;
    logic [7:0]     gen_reg, gen_next;
    logic           rsp_valid_reg, rsp_valid_next;

    // Row buffers and request payload
    logic [MAX_WIDTH-1:0] above_reg, above_next;
    logic [MAX_WIDTH-1:0] mid_reg, mid_next;
    logic [MAX_WIDTH-1:0] below_reg, below_next;
    logic [MAX_WIDTH-1:0] next_row_reg, next_row_next;
    logic [1:0]           req_op_reg, req_op_next;
    logic [XW-1:0]        req_col_reg, req_col_next;
    logic [YW-1:0]        req_row_reg, req_row_next;
    logic                 req_cell_reg, req_cell_next;
    logic                 req_inside_reg, req_inside_next;
    logic                 result_reg, result_next;
    logic                 rsp_cell_reg, rsp_cell_next;
    logic [1:0]           rsp_op_reg, rsp_op_next;

    // Memory port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [MAX_WIDTH-1:0] ram_wdata;
    logic [MAX_WIDTH-1:0] ram_rdata;

    // Derived values
    logic [EW-1:0]        gw_ext, eff_w;
    logic [EH-1:0]        gh_ext, eff_h;
    logic [EW-1:0]        col_ext;
    logic [EH-1:0]        row_ext;
    logic                 req_accept;
    logic                 rsp_free;
    logic [MAX_WIDTH-1:0] col_mask;
    logic [MAX_WIDTH-1:0] rd_masked;
    logic [EH-1:0]        y_m1, y_p1;
    logic [EW-1:0]        x_m1, x_p1;
    logic                 last_row;
    logic                 last_gen;
    logic [7:0]           nbr;
    logic [3:0]           floors;
    logic [3:0]           walls;
    logic [3:0]           limit;
    logic                 new_cell;

    // Bit of a row, zero beyond the stored width
    function automatic logic pick(input logic [MAX_WIDTH-1:0] v, input logic [EW-1:0] idx);
        logic b;
        b = 1'b0;
        if (idx < EW'(MAX_WIDTH))
        begin
            b = v[idx[XW-1:0]];
        end
        return b;
    endfunction

    cave_ca_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Effective grid size, saturated to the memory size
    assign gw_ext  = EW'(grid_width_reg);
    assign gh_ext  = EH'(grid_height_reg);
    assign eff_w   = (gw_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : gw_ext;
    assign eff_h   = (gh_ext > EH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : gh_ext;
    assign col_ext = EW'(col);
    assign row_ext = EH'(row);

    // Columns in use
    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            col_mask[i] = (EW'(i) < eff_w);
        end
    end
    assign rd_masked = ram_rdata & col_mask;

    // Handshakes
    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && (state_reg == S_IDLE);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign cell_out   = rsp_cell_reg;
    assign op_done    = rsp_op_reg;

    // Sweep position
    assign y_m1     = y_reg - EH'(1);
    assign y_p1     = y_reg + EH'(1);
    assign x_m1     = x_reg - EW'(1);
    assign x_p1     = x_reg + EW'(1);
    assign last_row = (y_reg == EH'(MAX_HEIGHT - 1));
    assign last_gen = ((gen_reg + 8'd1) == generations_reg);

    // Shared neighbor counter and 4-5 rule
    always_comb
    begin
        nbr[0] = (x_reg != '0) && pick(above_reg, x_m1);
        nbr[1] = pick(above_reg, x_reg);
        nbr[2] = pick(above_reg, x_p1);
        nbr[3] = (x_reg != '0) && pick(mid_reg, x_m1);
        nbr[4] = pick(mid_reg, x_p1);
        nbr[5] = (x_reg != '0) && pick(below_reg, x_m1);
        nbr[6] = pick(below_reg, x_reg);
        nbr[7] = pick(below_reg, x_p1);
        floors = '0;
        for (int k = 0; k < 8; k++)
        begin
            floors = floors + 4'(nbr[k]);
        end
        walls    = 4'd8 - floors;
        limit    = pick(mid_reg, x_reg) ? f2w_reg : keep_reg;
        new_cell = (walls >= limit) ? 1'b0 : 1'b1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (op) inside
                        OP_LOAD, OP_READ: state_next = S_ACCESS;
                        OP_RUN:           state_next = (generations_reg == 8'd0) ? S_DONE
                                                                             : S_GEN_CUR;
                        default:          state_next = S_DONE;
                    endcase
                end
            end
            S_ACCESS:    state_next = (req_op_reg == OP_LOAD) ? S_LD_WR : S_RD_CAP;
            S_LD_WR:     state_next = S_DONE;
            S_RD_CAP:    state_next = S_DONE;
            S_GEN_CUR:   state_next = S_GEN_ABOVE;
            S_GEN_ABOVE: state_next = (y_reg < eff_h) ? S_GEN_BELOW : S_GEN_WRITE;
            S_GEN_BELOW: state_next = S_GEN_FILL;
            S_GEN_FILL:  state_next = (eff_w == '0) ? S_GEN_WRITE : S_GEN_CELL;
            S_GEN_CELL:  state_next = (x_p1 == eff_w) ? S_GEN_WRITE : S_GEN_CELL;
            S_GEN_WRITE: state_next = (last_row && last_gen) ? S_DONE : S_GEN_CUR;
            S_DONE:      state_next = rsp_free ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Memory port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {~bank_reg, y_reg[YW-1:0]};
        ram_wdata = next_row_reg;
        ram_raddr = {bank_reg, y_reg[YW-1:0]};
        unique case (state_reg)
            S_ACCESS:    ram_raddr = {bank_reg, req_row_reg};
            S_GEN_ABOVE: ram_raddr = {bank_reg, y_m1[YW-1:0]};
            S_GEN_BELOW: ram_raddr = {bank_reg, y_p1[YW-1:0]};
            S_LD_WR:
            begin
                ram_we    = req_inside_reg;
                ram_waddr = {bank_reg, req_row_reg};
                ram_wdata = ram_rdata;
                ram_wdata[req_col_reg] = req_cell_reg;
            end
            S_GEN_WRITE: ram_we = 1'b1;
            default:     ram_we = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        bank_next       = bank_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        gen_next        = gen_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        above_next      = above_reg;
        mid_next        = mid_reg;
        below_next      = below_reg;
        next_row_next   = next_row_reg;
        req_op_next     = req_op_reg;
        req_col_next    = req_col_reg;
        req_row_next    = req_row_reg;
        req_cell_next   = req_cell_reg;
        req_inside_next = req_inside_reg;
        result_next     = result_reg;
        rsp_cell_next   = rsp_cell_reg;
        rsp_op_next     = rsp_op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    req_op_next     = op;
                    req_col_next    = col_ext[XW-1:0];
                    req_row_next    = row_ext[YW-1:0];
                    req_cell_next   = cell_in;
                    req_inside_next = (col_ext < eff_w) && (row_ext < eff_h);
                    result_next     = 1'b0;
                    x_next          = '0;
                    y_next          = '0;
                    gen_next        = '0;
                end
            end
            S_RD_CAP:
            begin
                result_next = req_inside_reg && ram_rdata[req_col_reg];
            end
            S_GEN_ABOVE:
            begin
                next_row_next = ram_rdata;
                mid_next      = rd_masked;
            end
            S_GEN_BELOW:
            begin
                above_next = (y_reg == '0) ? '0 : rd_masked;
            end
            S_GEN_FILL:
            begin
                below_next = (y_p1 < eff_h) ? rd_masked : '0;
                x_next     = '0;
            end
            S_GEN_CELL:
            begin
                next_row_next[x_reg[XW-1:0]] = new_cell;
                x_next = x_p1;
            end
            S_GEN_WRITE:
            begin
                if (last_row)
                begin
                    y_next    = '0;
                    bank_next = ~bank_reg;
                    gen_next  = gen_reg + 8'd1;
                end
                else
                begin
                    y_next = y_p1;
                end
            end
            S_DONE:
            begin
                // response payload only moves once the output register is free
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_cell_next  = result_reg;
                    rsp_op_next    = req_op_reg;
                end
            end
            default:
            begin
                bank_next = bank_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bank_reg      <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            gen_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            gen_reg       <= gen_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        above_reg      <= above_next;
        mid_reg        <= mid_next;
        below_reg      <= below_next;
        next_row_reg   <= next_row_next;
        req_op_reg     <= req_op_next;
        req_col_reg    <= req_col_next;
        req_row_reg    <= req_row_next;
        req_cell_reg   <= req_cell_next;
        req_inside_reg <= req_inside_next;
        result_reg     <= result_next;
        rsp_cell_reg   <= rsp_cell_next;
        rsp_op_reg     <= rsp_op_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RST_GRID_WIDTH;
            grid_height_reg <= RST_GRID_HEIGHT;
            generations_reg <= RST_GENERATIONS;
            f2w_reg         <= RST_FLOOR_TO_WALL;
            keep_reg        <= RST_WALL_KEEP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:    grid_width_reg  <= cfg_data[6:0];
                REG_GRID_HEIGHT:   grid_height_reg <= cfg_data[6:0];
                REG_GENERATIONS:   generations_reg <= cfg_data;
                REG_FLOOR_TO_WALL: f2w_reg         <= cfg_data[3:0];
                REG_WALL_KEEP:     keep_reg        <= cfg_data[3:0];
                default:           grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // Checks
    `CAVE_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_reg), $past(state_reg == S_DONE))
    `CAVE_ASSERT_IMP(a_cell_in_range, state_reg == S_GEN_CELL, x_reg < eff_w)
    `CAVE_ASSERT_IMP(a_gen_write_bank, state_reg == S_GEN_WRITE, ram_waddr[AW-1] != bank_reg)
    `CAVE_ASSERT_NEXT(a_accept_busy, req_accept, state_reg != S_IDLE)

endmodule

`default_nettype wire
